// ----- rtl/exposure_timer_keypad_controller_unit_assert.svh -----
// Assertion macros shared by the exposure timer keypad controller RTL.
// Expects clk and rst_n (synchronous, active low) in the including scope.
`ifndef EXPOSURE_TIMER_KEYPAD_CONTROLLER_UNIT_ASSERT_SVH
`define EXPOSURE_TIMER_KEYPAD_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ETKC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/etkc_pkg.sv -----
// Package for the exposure timer keypad controller: widths, mode and button
// codes, register indexes and reset defaults. No dependencies.
package etkc_pkg;

  localparam int BTN_W    = 3;
  localparam int MODE_W   = 3;
  localparam int TIME_W   = 13;
  localparam int DISP_W   = 14;
  localparam int CNT_W    = 16;
  localparam int STEP_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam int PRESET_SLOTS_DEF = 4;
  localparam int MAX_SECONDS_DEF  = 5999;

  // Modes
  localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PRE1   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRE2   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PRE3   = 3'd7;

  // Buttons
  localparam logic [BTN_W-1:0] BTN_NONE  = 3'd0;
  localparam logic [BTN_W-1:0] BTN_UP    = 3'd1;
  localparam logic [BTN_W-1:0] BTN_DEC   = 3'd2;
  localparam logic [BTN_W-1:0] BTN_RUN   = 3'd3;
  localparam logic [BTN_W-1:0] BTN_PRE1  = 3'd4;
  localparam logic [BTN_W-1:0] BTN_PRE3  = 3'd6;

  // Offsets between preset modes, slots and buttons
  localparam logic [MODE_W-1:0] MODE_TO_SLOT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TO_BTN  = 3'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FIRST        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SECOND       = 3'd5;

  // Register reset values
  localparam logic [CNT_W-1:0]  TPS_RST   = 16'd20;
  localparam logic [CNT_W-1:0]  HOLD1_RST = 16'd20;
  localparam logic [CNT_W-1:0]  HOLD2_RST = 16'd40;
  localparam logic [CNT_W-1:0]  REP_RST   = 16'd2;
  localparam logic [STEP_W-1:0] STEP1_RST = 8'd10;
  localparam logic [STEP_W-1:0] STEP2_RST = 8'd60;

  // Step phases
  localparam logic [1:0] PHASE_ONE    = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  // Divide by sixty: floor(t * 1092 / 2^16) is floor(t/60) or one less
  // for t below 6000; one compare-and-subtract fixes it.
  localparam int            SEC_PER_MIN = 60;
  localparam logic [10:0]   RECIP60     = 11'd1092;
  localparam int            RECIP_SHIFT = 16;

endpackage

// ----- rtl/etkc_disp.sv -----
// Seconds to minutes*100+seconds display conversion with blanking.
// Depends on etkc_pkg.
module etkc_disp (
  input  logic [etkc_pkg::TIME_W-1:0] seconds,
  input  logic                        lit,
  output logic [etkc_pkg::DISP_W-1:0] value
);

  logic [23:0] prod;
  logic [6:0]  q_est;
  logic [6:0]  q_fix;
  logic [12:0] q_x60;
  logic [12:0] r_wide;
  logic [6:0]  r_est;
  logic [6:0]  r_fix;
  logic [13:0] q_x100;

  always_comb begin
    prod   = 24'(seconds) * 24'(etkc_pkg::RECIP60);
    q_est  = prod[etkc_pkg::RECIP_SHIFT+6:etkc_pkg::RECIP_SHIFT];
    // 60q = 64q - 4q
    q_x60  = (13'(q_est) << 6) - (13'(q_est) << 2);
    r_wide = seconds - q_x60;
    r_est  = r_wide[6:0];
    if (r_est >= 7'(etkc_pkg::SEC_PER_MIN)) begin
      q_fix = q_est + 7'd1;
      r_fix = r_est - 7'(etkc_pkg::SEC_PER_MIN);
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
    // 100q = 64q + 32q + 4q
    q_x100 = (14'(q_fix) << 6) + (14'(q_fix) << 5) + (14'(q_fix) << 2);
    value  = lit ? (q_x100 + 14'(r_fix)) : '0;
  end

endmodule

// ----- rtl/exposure_timer_keypad_controller_unit.sv -----
// Exposure timer keypad controller, top level. Depends on etkc_pkg, etkc_disp and the assert header.
// Each transaction passes through the state register, then the result register, to reach out_tvalid.
// Throughput: one transaction per cycle; a stalled result blocks input only when both stages
//   hold a result.
// Reset (rst_n low, synchronous): mode init, timer and presets zero, counters and
//   configuration registers at their defaults, both stages empty.
module exposure_timer_keypad_controller_unit #(
  parameter int PRESET_SLOTS = etkc_pkg::PRESET_SLOTS_DEF,
  parameter int MAX_SECONDS  = etkc_pkg::MAX_SECONDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [etkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [etkc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [etkc_pkg::IN_DATA_W-1:0]    in_tdata,   // [2:0] button, [7:3] zero
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [etkc_pkg::OUT_DATA_W-1:0]   out_tdata   // [13:0] display_value,
                                                        // [14] display_on,
                                                        // [15] lamp_on,
                                                        // [18:16] mode,
                                                        // [31:19] seconds_left
);

  localparam int SLOT_W = $clog2(PRESET_SLOTS);
  localparam logic [etkc_pkg::TIME_W-1:0] MAX_T = etkc_pkg::TIME_W'(MAX_SECONDS);

  // ---------------------------------------------------------------------
  // Configuration registers: always ready, writes are registered.
  // ---------------------------------------------------------------------
  logic [etkc_pkg::CNT_W-1:0]  tps_r, hold1_r, hold2_r, rep_int_r;
  logic [etkc_pkg::STEP_W-1:0] step1_r, step2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= etkc_pkg::TPS_RST;
      hold1_r   <= etkc_pkg::HOLD1_RST;
      hold2_r   <= etkc_pkg::HOLD2_RST;
      rep_int_r <= etkc_pkg::REP_RST;
      step1_r   <= etkc_pkg::STEP1_RST;
      step2_r   <= etkc_pkg::STEP2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        etkc_pkg::REG_TICKS_PER_SECOND:  tps_r     <= cfg_data;
        etkc_pkg::REG_HOLD_DELAY_FIRST:  hold1_r   <= cfg_data;
        etkc_pkg::REG_HOLD_DELAY_SECOND: hold2_r   <= cfg_data;
        etkc_pkg::REG_REPEAT_INTERVAL:   rep_int_r <= cfg_data;
        etkc_pkg::REG_STEP_FIRST:        step1_r   <= cfg_data[etkc_pkg::STEP_W-1:0];
        etkc_pkg::REG_STEP_SECOND:       step2_r   <= cfg_data[etkc_pkg::STEP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. Stage one is the controller state itself: while a result is
  // pending there (st_valid_r), the state registers hold exactly that
  // result. The result register takes it when it is empty or being drained,
  // and a new input transaction may update the state in that same cycle.
  // ---------------------------------------------------------------------
  logic st_valid_r, st_valid_nxt;
  logic out_valid_r;
  logic st_adv;
  logic in_acc;

  assign st_adv    = !out_valid_r || out_tready;
  assign in_tready = !st_valid_r || st_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_acc) begin
      st_valid_nxt = 1'b1;
    end else if (st_adv) begin
      st_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  logic [etkc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [etkc_pkg::TIME_W-1:0] timer_r, timer_nxt;
  logic [etkc_pkg::TIME_W-1:0] store_r   [PRESET_SLOTS];
  logic [etkc_pkg::TIME_W-1:0] store_nxt [PRESET_SLOTS];
  logic [etkc_pkg::CNT_W-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [etkc_pkg::CNT_W-1:0]  rep_cnt_r, rep_cnt_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic                        pending_r, pending_nxt;
  logic                        started_r, started_nxt;
  logic [etkc_pkg::CNT_W-1:0]  sec_cnt_r, sec_cnt_nxt;
  logic                        released_r, released_nxt;
  logic                        exit_pend_r, exit_pend_nxt;
  logic                        pre_phase_r, pre_phase_nxt;
  logic [etkc_pkg::CNT_W-1:0]  pre_cnt_r, pre_cnt_nxt;
  logic                        lit_r, lit_nxt;

  logic [etkc_pkg::BTN_W-1:0]  btn;
  logic [etkc_pkg::STEP_W-1:0] step;
  logic [etkc_pkg::DISP_W-1:0] up_sum;
  logic [etkc_pkg::MODE_W-1:0] slot;
  logic [SLOT_W-1:0]           slot_idx;
  logic                        slot_ok;
  logic [etkc_pkg::TIME_W-1:0] slot_val;
  logic                        second;
  logic                        leave;
  logic                        lamp_on;
  logic                        in_preset;

  assign btn       = in_tdata[etkc_pkg::BTN_W-1:0];
  assign slot      = mode_r - etkc_pkg::MODE_TO_SLOT;
  assign slot_idx  = slot[SLOT_W-1:0];
  assign slot_ok   = (int'(slot) < PRESET_SLOTS);
  assign slot_val  = slot_ok ? store_r[slot_idx] : '0;
  assign lamp_on   = (mode_r == etkc_pkg::MODE_ACTIVE);
  assign in_preset = (mode_r >= etkc_pkg::MODE_PRE1);

  always_comb begin
    case (phase_r)
      etkc_pkg::PHASE_ONE:   step = 8'd1;
      etkc_pkg::PHASE_FIRST: step = step1_r;
      default:               step = step2_r;
    endcase
    up_sum = 14'(timer_r) + 14'(step);
  end

  always_comb begin
    mode_nxt      = mode_r;
    timer_nxt     = timer_r;
    store_nxt     = store_r;
    hold_cnt_nxt  = hold_cnt_r;
    rep_cnt_nxt   = rep_cnt_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    started_nxt   = started_r;
    sec_cnt_nxt   = sec_cnt_r;
    released_nxt  = released_r;
    exit_pend_nxt = exit_pend_r;
    pre_phase_nxt = pre_phase_r;
    pre_cnt_nxt   = pre_cnt_r;
    lit_nxt       = lit_r;
    second        = 1'b0;
    leave         = 1'b0;

    case (mode_r)
      etkc_pkg::MODE_INIT: begin
        mode_nxt = etkc_pkg::MODE_IDLE;
      end

      etkc_pkg::MODE_IDLE: begin
        if (btn == etkc_pkg::BTN_UP) begin
          mode_nxt = etkc_pkg::MODE_UP;
        end else if (btn == etkc_pkg::BTN_DEC) begin
          mode_nxt = etkc_pkg::MODE_DOWN;
        end else if (btn == etkc_pkg::BTN_RUN) begin
          mode_nxt     = etkc_pkg::MODE_ACTIVE;
          store_nxt[0] = timer_r;
        end else if (btn >= etkc_pkg::BTN_PRE1 && btn <= etkc_pkg::BTN_PRE3) begin
          mode_nxt = btn + etkc_pkg::MODE_TO_BTN;
        end
      end

      etkc_pkg::MODE_UP, etkc_pkg::MODE_DOWN: begin
        if ((mode_r == etkc_pkg::MODE_UP   && btn == etkc_pkg::BTN_UP) ||
            (mode_r == etkc_pkg::MODE_DOWN && btn == etkc_pkg::BTN_DEC)) begin
          // Apply a pending step, then run repeat and hold counters.
          if (pending_r) begin
            if (mode_r == etkc_pkg::MODE_UP) begin
              timer_nxt = (up_sum > 14'(MAX_T)) ? MAX_T : up_sum[etkc_pkg::TIME_W-1:0];
            end else begin
              timer_nxt = (timer_r > 13'(step)) ? timer_r - 13'(step) : '0;
            end
            lit_nxt     = 1'b1;
            pending_nxt = 1'b0;
          end
          if (rep_cnt_r != '0 && started_r) begin
            rep_cnt_nxt = rep_cnt_r - 16'd1;
          end else if (rep_cnt_r == '0) begin
            pending_nxt = 1'b1;
            rep_cnt_nxt = rep_int_r;
          end
          if (hold_cnt_r != '0) begin
            hold_cnt_nxt = hold_cnt_r - 16'd1;
          end else begin
            phase_nxt    = (phase_r == etkc_pkg::PHASE_ONE) ? etkc_pkg::PHASE_FIRST
                                                            : etkc_pkg::PHASE_SECOND;
            started_nxt  = 1'b1;
            pending_nxt  = 1'b1;
            hold_cnt_nxt = hold2_r;
          end
        end else if (btn == etkc_pkg::BTN_NONE) begin
          mode_nxt     = etkc_pkg::MODE_IDLE;
          pending_nxt  = 1'b1;
          started_nxt  = 1'b0;
          phase_nxt    = etkc_pkg::PHASE_ONE;
          hold_cnt_nxt = hold1_r;
          rep_cnt_nxt  = rep_int_r;
        end
      end

      etkc_pkg::MODE_ACTIVE: begin
        if (btn == etkc_pkg::BTN_NONE && exit_pend_r) begin
          exit_pend_nxt = 1'b0;
          released_nxt  = 1'b0;
          mode_nxt      = etkc_pkg::MODE_IDLE;
        end else if (btn == etkc_pkg::BTN_NONE) begin
          released_nxt = 1'b1;
          if (sec_cnt_r != '0) begin
            sec_cnt_nxt = sec_cnt_r - 16'd1;
          end else begin
            sec_cnt_nxt = tps_r;
            second      = 1'b1;
          end
          if (timer_r != '0 && second) begin
            timer_nxt = timer_r - 13'd1;
            lit_nxt   = 1'b1;
          end else if (timer_r == '0) begin
            exit_pend_nxt = 1'b1;
          end
        end else if (released_r) begin
          released_nxt  = 1'b0;
          exit_pend_nxt = 1'b1;
        end
      end

      default: begin
        // Preset modes: hold to store, release early to load.
        if (btn == mode_r - etkc_pkg::MODE_TO_BTN) begin
          if (pre_cnt_r != '0) begin
            pre_cnt_nxt = pre_cnt_r - 16'd1;
          end else if (!pre_phase_r) begin
            pre_cnt_nxt   = tps_r >> 1;
            pre_phase_nxt = 1'b1;
            lit_nxt       = 1'b0;
            if (slot_ok) begin
              store_nxt[slot_idx] = timer_r;
            end
          end else begin
            lit_nxt = 1'b1;
            leave   = 1'b1;
          end
        end else begin
          store_nxt[0] = slot_val;
          timer_nxt    = slot_val;
          lit_nxt      = 1'b1;
          leave        = 1'b1;
        end
        if (leave) begin
          pre_phase_nxt = 1'b0;
          pre_cnt_nxt   = tps_r;
          mode_nxt      = etkc_pkg::MODE_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      mode_r      <= etkc_pkg::MODE_INIT;
      timer_r     <= '0;
      for (int i = 0; i < PRESET_SLOTS; i++) begin
        store_r[i] <= '0;
      end
      hold_cnt_r  <= etkc_pkg::HOLD1_RST;
      rep_cnt_r   <= etkc_pkg::REP_RST;
      phase_r     <= etkc_pkg::PHASE_ONE;
      pending_r   <= 1'b1;
      started_r   <= 1'b0;
      sec_cnt_r   <= etkc_pkg::TPS_RST;
      released_r  <= 1'b0;
      exit_pend_r <= 1'b0;
      pre_phase_r <= 1'b0;
      pre_cnt_r   <= etkc_pkg::TPS_RST;
      lit_r       <= 1'b1;
    end else begin
      st_valid_r <= st_valid_nxt;
      // Advance the controller only on an accepted transaction.
      if (in_acc) begin
        mode_r      <= mode_nxt;
        timer_r     <= timer_nxt;
        store_r     <= store_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
        rep_cnt_r   <= rep_cnt_nxt;
        phase_r     <= phase_nxt;
        pending_r   <= pending_nxt;
        started_r   <= started_nxt;
        sec_cnt_r   <= sec_cnt_nxt;
        released_r  <= released_nxt;
        exit_pend_r <= exit_pend_nxt;
        pre_phase_r <= pre_phase_nxt;
        pre_cnt_r   <= pre_cnt_nxt;
        lit_r       <= lit_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: display conversion from the settled state.
  // ---------------------------------------------------------------------
  logic [etkc_pkg::DISP_W-1:0]     disp_value;
  logic [etkc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_blank;

  etkc_disp u_disp (
    .seconds (timer_r),
    .lit     (lit_r),
    .value   (disp_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_adv) begin
      out_valid_r <= st_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv && st_valid_r) begin
      out_data_r <= {timer_r, mode_r, lamp_on, lit_r, disp_value};
    end
  end

  assign out_tdata = out_data_r;
  assign out_blank = out_valid_r && !out_data_r[14];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "exposure_timer_keypad_controller_unit_assert.svh"

  `ETKC_ASSERT_SAME(a_timer_max, 1'b1, timer_r <= MAX_T, "timer above maximum")
  `ETKC_ASSERT_SAME(a_blank_zero, out_blank, out_data_r[13:0] == '0, "blank display nonzero")
  `ETKC_ASSERT_SAME(a_exit_active, exit_pend_r, lamp_on, "exit pending outside active mode")
  `ETKC_ASSERT_SAME(a_pre_phase, pre_phase_r, in_preset, "preset phase outside preset mode")
  `ETKC_ASSERT_NEXT(a_acc_pending, in_acc, st_valid_r, "accepted transaction left no result")

endmodule
